// ===== hw/rtl/vat_pkg.sv =====
// Package for the vertex affine transform block.
// Holds register indexes, reset values and pipeline depths; no dependencies.
package vat_pkg;

  localparam int NUM_REGS   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int Q_ONE      = 65536;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_R0_AB = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_R0_CT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_R1_AB = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_R1_CT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_R2_AB = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_R2_CT = 3'd5;

  // Reset matrix is the identity.
  localparam logic [63:0] RST_R0_AB = 64'h0001_0000_0000_0000;
  localparam logic [63:0] RST_R0_CT = 64'h0000_0000_0000_0000;
  localparam logic [63:0] RST_R1_AB = 64'h0000_0000_0001_0000;
  localparam logic [63:0] RST_R1_CT = 64'h0000_0000_0000_0000;
  localparam logic [63:0] RST_R2_AB = 64'h0000_0000_0000_0000;
  localparam logic [63:0] RST_R2_CT = 64'h0001_0000_0000_0000;

  // Pipeline depths.
  localparam int ROW_STAGES  = 3;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 17;
  localparam int DIV_W       = 50;

endpackage

// ===== hw/rtl/vat_dly.sv =====
// Fixed-length register delay line for payload alignment.
// Depends on nothing.
module vat_dly #(
  parameter int W = 32,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [D];

  always_ff @(posedge clk) begin
    tap_r[0] <= din;
    for (int i = 1; i < D; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign dout = tap_r[D-1];

endmodule

// ===== hw/rtl/vat_row.sv =====
// One matrix row: three products, rounded sum plus translation, saturation.
// Three register stages; uses vat_pkg.
module vat_row import vat_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic signed [31:0] c,
  input  logic signed [31:0] t,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  input  logic signed [31:0] z,
  output logic signed [31:0] res
);

  logic signed [63:0] p0_r, p1_r, p2_r;
  logic signed [31:0] t_r;
  logic signed [65:0] sum_w;
  logic signed [50:0] acc_nxt, acc_r;
  logic signed [31:0] res_nxt, res_r;

  always_comb begin
    sum_w = 66'(p0_r) + 66'(p1_r) + 66'(p2_r) + 66'sd32768;
    // The rounded sum keeps its sign when it is widened.
    acc_nxt = 51'($signed(sum_w[65:16])) + 51'(t_r);
    if (acc_r > 51'sd2147483647) begin
      res_nxt = 32'sh7fff_ffff;
    end else if (acc_r < -51'sd2147483648) begin
      res_nxt = 32'sh8000_0000;
    end else begin
      res_nxt = acc_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    p0_r  <= 64'(a) * 64'(x);
    p1_r  <= 64'(b) * 64'(y);
    p2_r  <= 64'(c) * 64'(z);
    t_r   <= t;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

// ===== hw/rtl/vat_isqrt.sv =====
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// Uses vat_pkg for the stage count.
module vat_isqrt import vat_pkg::*; (
  input  logic        clk,
  input  logic [63:0] s_in,
  output logic [31:0] root
);

  logic [63:0] s_r   [SQRT_STEPS];
  logic [63:0] res_r [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    logic [63:0] s_w, res_w, bit_w, trial_w;
    logic [63:0] s_nxt, res_nxt;

    if (i == 0) begin : g_first
      assign s_w   = s_in;
      assign res_w = '0;
    end else begin : g_rest
      assign s_w   = s_r[i-1];
      assign res_w = res_r[i-1];
    end

    always_comb begin
      bit_w   = 64'(1) << (62 - 2 * i);
      trial_w = res_w + bit_w;
      if (s_w >= trial_w) begin
        s_nxt   = s_w - trial_w;
        res_nxt = (res_w >> 1) + bit_w;
      end else begin
        s_nxt   = s_w;
        res_nxt = res_w >> 1;
      end
    end

    always_ff @(posedge clk) begin
      s_r[i]   <= s_nxt;
      res_r[i] <= res_nxt;
    end
  end

  assign root = res_r[SQRT_STEPS-1][31:0];

endmodule

// ===== hw/rtl/vat_div.sv =====
// Pipelined restoring divider: round(m * 2^16 / r), one quotient bit per stage.
// Uses vat_pkg for the stage count and remainder width.
module vat_div import vat_pkg::*; (
  input  logic                 clk,
  input  logic [31:0]          m,
  input  logic [31:0]          r,
  output logic [DIV_STEPS-1:0] q
);

  logic [DIV_W-1:0]     rem_r [DIV_STEPS];
  logic [31:0]          den_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_r [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [DIV_W-1:0]     rem_w, sub_w, rem_nxt;
    logic [31:0]          den_w;
    logic [DIV_STEPS-1:0] quo_w, quo_nxt;

    if (j == 0) begin : g_first
      assign rem_w = (DIV_W'(m) << 16) + DIV_W'(r >> 1);
      assign den_w = r;
      assign quo_w = '0;
    end else begin : g_rest
      assign rem_w = rem_r[j-1];
      assign den_w = den_r[j-1];
      assign quo_w = quo_r[j-1];
    end

    always_comb begin
      sub_w = DIV_W'(den_w) << (DIV_STEPS - 1 - j);
      if (rem_w >= sub_w) begin
        rem_nxt = rem_w - sub_w;
        quo_nxt = {quo_w[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_nxt = rem_w;
        quo_nxt = {quo_w[DIV_STEPS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j] <= rem_nxt;
      den_r[j] <= den_w;
      quo_r[j] <= quo_nxt;
    end
  end

  assign q = quo_r[DIV_STEPS-1];

endmodule

// ===== hw/rtl/vertex_affine_transform_normalize.sv =====
// Top level of the vertex affine transform with normal renormalization.
// Depends on vat_pkg, vat_row, vat_isqrt, vat_div and vat_dly.
//
// The block accepts one vertex in every clock cycle (busy stays low) and
// returns each result, marked by a one-cycle out_valid strobe; the
// receiver cannot stall the output, so results leave in input order with
// no gaps added. The latency is set by the normal path: three stages of
// matrix row arithmetic, one normalizing shift, squaring and summing, a
// 32-stage square root, a 17-stage divider and the output register. The
// position and texture paths are delayed to match.
// Configuration writes are always ready and take effect at once; write only
// while no vertex is in flight.
module vertex_affine_transform_normalize import vat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Vertex input channel.
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   in_pos_x,
  input  logic signed [31:0]   in_pos_y,
  input  logic signed [31:0]   in_pos_z,
  input  logic                 in_has_normal,
  input  logic signed [31:0]   in_nrm_x,
  input  logic signed [31:0]   in_nrm_y,
  input  logic signed [31:0]   in_nrm_z,
  input  logic                 in_has_uv,
  input  logic signed [31:0]   in_uv_u,
  input  logic signed [31:0]   in_uv_v,
  // Result channel.
  output logic                 out_valid,
  output logic signed [31:0]   out_x,
  output logic signed [31:0]   out_y,
  output logic signed [31:0]   out_z,
  output logic signed [31:0]   out_nx,
  output logic signed [31:0]   out_ny,
  output logic signed [31:0]   out_nz,
  output logic signed [31:0]   out_u,
  output logic signed [31:0]   out_v,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  // Stage numbers counted from the start transfer.
  localparam int NORM_STAGE = ROW_STAGES + 1;
  localparam int SQRT_DONE  = NORM_STAGE + 2 + SQRT_STEPS;
  localparam int DIV_DONE   = SQRT_DONE + DIV_STEPS;
  localparam int OUT_LAT    = DIV_DONE + 1;

  // The pipeline never stalls, so both channels are always open.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // ------------------------------------------------------------------
  // Matrix registers.
  // ------------------------------------------------------------------
  logic [63:0] mat_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[REG_R0_AB] <= RST_R0_AB;
      mat_r[REG_R0_CT] <= RST_R0_CT;
      mat_r[REG_R1_AB] <= RST_R1_AB;
      mat_r[REG_R1_CT] <= RST_R1_CT;
      mat_r[REG_R2_AB] <= RST_R2_AB;
      mat_r[REG_R2_CT] <= RST_R2_CT;
    end else if (cfg_valid && cfg_ready) begin
      // An index beyond the register list is a silent no-op.
      case (cfg_index)
        REG_R0_AB: mat_r[REG_R0_AB] <= cfg_data;
        REG_R0_CT: mat_r[REG_R0_CT] <= cfg_data;
        REG_R1_AB: mat_r[REG_R1_AB] <= cfg_data;
        REG_R1_CT: mat_r[REG_R1_CT] <= cfg_data;
        REG_R2_AB: mat_r[REG_R2_AB] <= cfg_data;
        REG_R2_CT: mat_r[REG_R2_CT] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Valid line: one bit per stage, cleared by reset.
  // ------------------------------------------------------------------
  logic vld_r [OUT_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < OUT_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= start && !busy;
      for (int i = 1; i < OUT_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // ------------------------------------------------------------------
  // Row units: three for the position, three for the normal.
  // ------------------------------------------------------------------
  logic signed [31:0] pos_w [3];
  logic signed [31:0] nrm_w [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    vat_row u_pos (
      .clk (clk),
      .a   (mat_r[2*r][63:32]),
      .b   (mat_r[2*r][31:0]),
      .c   (mat_r[2*r+1][63:32]),
      .t   (mat_r[2*r+1][31:0]),
      .x   (in_pos_x),
      .y   (in_pos_y),
      .z   (in_pos_z),
      .res (pos_w[r])
    );
    vat_row u_nrm (
      .clk (clk),
      .a   (mat_r[2*r][63:32]),
      .b   (mat_r[2*r][31:0]),
      .c   (mat_r[2*r+1][63:32]),
      .t   (32'sd0),
      .x   (in_nrm_x),
      .y   (in_nrm_y),
      .z   (in_nrm_z),
      .res (nrm_w[r])
    );
  end

  // ------------------------------------------------------------------
  // Normalizing shift: scale all three magnitudes together until the
  // largest reaches 2^30, which keeps the direction and the precision.
  // ------------------------------------------------------------------
  logic [31:0] mag_w [3];
  logic [31:0] mx_w;
  logic [4:0]  hb_w, sh_w;
  logic [31:0] m_r [3];
  logic [2:0]  sgn_r;
  logic        zero_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_w[i] = nrm_w[i][31] ? 32'(-nrm_w[i]) : 32'(nrm_w[i]);
    end
    mx_w = mag_w[0];
    if (mag_w[1] > mx_w) mx_w = mag_w[1];
    if (mag_w[2] > mx_w) mx_w = mag_w[2];
    hb_w = '0;
    for (int i = 0; i < 32; i++) begin
      if (mx_w[i]) hb_w = 5'(i);
    end
    sh_w = (hb_w >= 5'd30) ? 5'd0 : 5'd30 - hb_w;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m_r[i]   <= mag_w[i] << sh_w;
      sgn_r[i] <= nrm_w[i][31];
    end
    zero_r <= (mx_w == 32'd0);
  end

  // Squares, then their sum; the sum stays below 2^64.
  logic [63:0] sq_r [3];
  logic [63:0] ssum_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= 64'(m_r[i]) * 64'(m_r[i]);
    end
    ssum_r <= sq_r[0] + sq_r[1] + sq_r[2];
  end

  logic [31:0] len_w;

  vat_isqrt u_isqrt (
    .clk  (clk),
    .s_in (ssum_r),
    .root (len_w)
  );

  // Scaled magnitudes wait alongside the square root.
  logic [95:0] m_dly_w;

  vat_dly #(.W(96), .D(SQRT_DONE - NORM_STAGE)) u_mdly (
    .clk  (clk),
    .din  ({m_r[0], m_r[1], m_r[2]}),
    .dout (m_dly_w)
  );

  logic [DIV_STEPS-1:0] q_w [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    vat_div u_div (
      .clk (clk),
      .m   (m_dly_w[95-32*i -: 32]),
      .r   (len_w),
      .q   (q_w[i])
    );
  end

  // ------------------------------------------------------------------
  // Side paths delayed to the divider output.
  // ------------------------------------------------------------------
  logic [95:0] pos_dly_w;
  logic [3:0]  nflag_dly_w;
  logic [65:0] side_dly_w;

  vat_dly #(.W(96), .D(DIV_DONE - ROW_STAGES)) u_pdly (
    .clk  (clk),
    .din  ({pos_w[0], pos_w[1], pos_w[2]}),
    .dout (pos_dly_w)
  );

  vat_dly #(.W(4), .D(DIV_DONE - NORM_STAGE)) u_ndly (
    .clk  (clk),
    .din  ({zero_r, sgn_r}),
    .dout (nflag_dly_w)
  );

  vat_dly #(.W(66), .D(DIV_DONE)) u_sdly (
    .clk  (clk),
    .din  ({in_has_normal, in_has_uv, in_uv_u, in_uv_v}),
    .dout (side_dly_w)
  );

  // ------------------------------------------------------------------
  // Output register: apply signs and the missing-normal and missing-uv
  // defaults. Bit i of the delayed flags is the sign of component i and
  // the top bit marks a zero-length normal.
  // ------------------------------------------------------------------
  logic signed [31:0] n_out_w [3];
  logic signed [31:0] ox_r, oy_r, oz_r, onx_r, ony_r, onz_r, ou_r, ov_r;
  logic               has_n_w, has_uv_w;

  assign has_n_w  = side_dly_w[65];
  assign has_uv_w = side_dly_w[64];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!has_n_w) begin
        n_out_w[i] = (i == 1) ? 32'(Q_ONE) : 32'sd0;
      end else if (nflag_dly_w[3]) begin
        n_out_w[i] = 32'sd0;
      end else if (nflag_dly_w[i]) begin
        n_out_w[i] = -32'(q_w[i]);
      end else begin
        n_out_w[i] = 32'(q_w[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    ox_r  <= pos_dly_w[95:64];
    oy_r  <= pos_dly_w[63:32];
    oz_r  <= pos_dly_w[31:0];
    onx_r <= n_out_w[0];
    ony_r <= n_out_w[1];
    onz_r <= n_out_w[2];
    ou_r  <= has_uv_w ? side_dly_w[63:32] : 32'sd0;
    ov_r  <= has_uv_w ? side_dly_w[31:0]  : 32'sd0;
  end

  assign out_valid = vld_r[OUT_LAT-1];
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_z     = oz_r;
  assign out_nx    = onx_r;
  assign out_ny    = ony_r;
  assign out_nz    = onz_r;
  assign out_u     = ou_r;
  assign out_v     = ov_r;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_nx <= 32'sd65536 && out_nx >= -32'sd65536 &&
                   out_ny <= 32'sd65536 && out_ny >= -32'sd65536 &&
                   out_nz <= 32'sd65536 && out_nz >= -32'sd65536))
    else $error("normal component exceeds unit length");

  a_ignored_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index > REG_R2_CT) |=>
      ($stable(mat_r[REG_R0_AB]) && $stable(mat_r[REG_R1_CT]) &&
       $stable(mat_r[REG_R2_CT])))
    else $error("write beyond register list changed the matrix");

  a_write_r0: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == REG_R0_AB) |=>
      (mat_r[REG_R0_AB] == $past(cfg_data)))
    else $error("configuration write not taken");

endmodule
